@@ sv/assert_macros.svh @@
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CHK_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/c8ie_pkg.sv @@
// Shared types, opcode codes and the font glyph table for the CHIP-8 execute block.
`default_nettype none
package c8ie_pkg;

    localparam int MEMORY_BYTES_DEF = 4096;
    localparam int STACK_DEPTH_DEF  = 16;
    localparam int DISPLAY_ROWS_DEF = 32;
    localparam int FONT_BYTES       = 80;
    localparam int NUM_VREGS        = 16;

    localparam logic [11:0] PC_RESET = 12'h200;

    typedef enum logic [1:0] {
        OP_EXEC      = 2'd0,
        OP_MEM_WRITE = 2'd1,
        OP_ROW_READ  = 2'd2,
        OP_REG_READ  = 2'd3
    } t_operation;

    typedef enum logic [3:0] {
        G_SYS  = 4'h0, G_JP   = 4'h1, G_CALL = 4'h2, G_SE   = 4'h3,
        G_SNE  = 4'h4, G_SER  = 4'h5, G_LD   = 4'h6, G_ADD  = 4'h7,
        G_ALU  = 4'h8, G_SNER = 4'h9, G_LDI  = 4'hA, G_JPV  = 4'hB,
        G_RND  = 4'hC, G_DRW  = 4'hD, G_KEY  = 4'hE, G_MISC = 4'hF
    } t_group;

    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [15:0] INS_CLS = 16'h00E0;
    localparam logic [15:0] INS_RET = 16'h00EE;

    localparam logic [7:0] KK_SKP      = 8'h9E;
    localparam logic [7:0] KK_SKNP     = 8'hA1;
    localparam logic [7:0] KK_LD_VX_DT = 8'h07;
    localparam logic [7:0] KK_LD_DT    = 8'h15;
    localparam logic [7:0] KK_LD_ST    = 8'h18;
    localparam logic [7:0] KK_ADD_I    = 8'h1E;
    localparam logic [7:0] KK_LD_F     = 8'h29;

    localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    function automatic logic [7:0] font_byte(input logic [6:0] idx);
        logic [7:0] val;
        val = 8'd0;
        if (int'(idx) < FONT_BYTES) begin
            val = FONT_ROM[idx];
        end
        return val;
    endfunction

endpackage
`default_nettype wire

@@ sv/c8ie_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module c8ie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ sv/chip8_instruction_execute_top.sv @@
// CHIP-8 execute block: top level with sequencer and state memories.
// Requests pass through RX to DONE; instructions through RX, RY, EXEC and DONE, flag ops adding WF.
// Draw: DMOD reduces I and Vy into range one subtraction at a time, then DRD and DWR
// alternate for each drawn row before WF and DONE.
// One request at a time; the sprite loop over memory and display ports sets the rate.
// Reset (synchronous, active low) clears registers, PC to 0x200, and valid bits of
// registers, stack, display rows and font; no clearing pass is needed.
`default_nettype none
module chip8_instruction_execute_top #(
    parameter int MEMORY_BYTES = c8ie_pkg::MEMORY_BYTES_DEF,
    parameter int STACK_DEPTH  = c8ie_pkg::STACK_DEPTH_DEF,
    parameter int DISPLAY_ROWS = c8ie_pkg::DISPLAY_ROWS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [15:0] i_instruction,
    input  wire logic [11:0] i_mem_address,
    input  wire logic [7:0]  i_mem_data,
    input  wire logic [7:0]  i_random_byte,
    input  wire logic [15:0] i_keys_pressed,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [11:0]      o_program_counter,
    output logic [11:0]      o_index_register,
    output logic [7:0]       o_flag_register,
    output logic [63:0]      o_read_data,
    output logic             o_not_implemented
);
    import c8ie_pkg::*;
    `include "assert_macros.svh"

    localparam int AW = $clog2(MEMORY_BYTES);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int RW = $clog2(DISPLAY_ROWS);

    typedef enum logic [3:0] {
        S_IDLE, S_RX, S_RY, S_EXEC, S_DMOD, S_DRD, S_DWR, S_WF, S_DONE
    } t_state;

    t_state r_state;

    // latched request
    t_operation  r_oper;
    logic [15:0] r_ins;
    logic [11:0] r_maddr;
    logic [7:0]  r_mdata;
    logic [7:0]  r_rnd;
    logic [15:0] r_keys;

    // architectural registers kept in flops
    logic [11:0]   r_pc, r_i;
    logic [7:0]    r_vf, r_dt, r_st;
    logic [SW-1:0] r_sp;

    // valid bits standing in for reset contents of the memories
    logic [NUM_VREGS-1:0]    r_vok;
    logic [STACK_DEPTH-1:0]  r_stk_ok;
    logic [DISPLAY_ROWS-1:0] r_row_ok;
    logic [FONT_BYTES-1:0]   r_font_wr;
    logic r_v_rok, r_s_rok, r_f_rok, r_font_sel;
    logic [6:0] r_font_idx;

    // working registers
    logic [7:0]  r_vx, r_vy, r_flag;
    logic [63:0] r_rd;
    logic        r_bad;
    logic [12:0] r_daddr;
    logic [7:0]  r_drow;
    logic [3:0]  r_di;
    logic        r_hit;

    // output register
    logic        r_out_valid;
    logic [11:0] r_o_pc, r_o_i;
    logic [7:0]  r_o_vf;
    logic [63:0] r_o_rd;
    logic        r_o_bad;

    // memory ports
    logic          v_we;
    logic [3:0]    v_waddr, v_raddr;
    logic [7:0]    v_wdata, v_rdata;
    logic          s_we;
    logic [SW-1:0] s_waddr;
    logic [11:0]   s_wdata, s_rdata;
    logic          f_we;
    logic [RW-1:0] f_waddr, f_raddr;
    logic [63:0]   f_wdata, f_rdata;
    logic          m_we;
    logic [AW-1:0] m_waddr, m_raddr;
    logic [7:0]    m_rdata;

    logic in_acc;
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // qualified read data: an entry never written reads as its reset value
    logic [7:0]  vreg_q, m_q;
    logic [11:0] stk_q;
    logic [63:0] frow_q;
    assign vreg_q = r_v_rok ? v_rdata : 8'd0;
    assign stk_q  = r_s_rok ? s_rdata : 12'd0;
    assign frow_q = r_f_rok ? f_rdata : 64'd0;
    assign m_q    = r_font_sel ? font_byte(r_font_idx) : m_rdata;

    // instruction fields
    t_group      grp;
    logic [3:0]  xi, nib;
    logic [7:0]  kk;
    logic [11:0] nnn;
    assign grp = t_group'(r_ins[15:12]);
    assign xi  = r_ins[11:8];
    assign nib = r_ins[3:0];
    assign kk  = r_ins[7:0];
    assign nnn = r_ins[11:0];

    logic [SW-1:0] sp_inc, sp_dec;
    assign sp_inc = (r_sp == SW'(STACK_DEPTH - 1)) ? '0 : r_sp + SW'(1);
    assign sp_dec = (r_sp == '0) ? SW'(STACK_DEPTH - 1) : r_sp - SW'(1);

    // execute decode
    logic [11:0]   n_pc, n_i, pc_adv;
    logic [SW-1:0] n_sp;
    logic [7:0]    n_dt, n_st, x_val, f_val;
    logic          n_bad, skip, x_we, f_set, stk_we, clr, draw, key_down;
    logic [8:0]    sum;

    always_comb begin
        sum      = {1'b0, r_vx} + {1'b0, r_vy};
        pc_adv   = r_pc + 12'd2;
        key_down = (r_vx[7:4] == 4'd0) && r_keys[r_vx[3:0]];
        skip     = 1'b0;
        n_pc     = pc_adv;
        n_i      = r_i;
        n_sp     = r_sp;
        n_dt     = r_dt;
        n_st     = r_st;
        n_bad    = 1'b0;
        x_we     = 1'b0;
        x_val    = r_vx;
        f_set    = 1'b0;
        f_val    = 8'd0;
        stk_we   = 1'b0;
        clr      = 1'b0;
        draw     = 1'b0;
        unique case (grp)
            G_SYS: begin
                if (r_ins == INS_CLS) begin
                    clr = 1'b1;
                end else if (r_ins == INS_RET) begin
                    n_pc = stk_q;
                    n_sp = sp_dec;
                end else begin
                    n_bad = 1'b1;
                end
            end
            G_JP: n_pc = nnn;
            G_CALL: begin
                n_sp   = sp_inc;
                stk_we = 1'b1;
                n_pc   = nnn;
            end
            G_SE:  skip = (r_vx == kk);
            G_SNE: skip = (r_vx != kk);
            G_SER: begin
                if (nib != 4'd0) n_bad = 1'b1;
                else             skip = (r_vx == r_vy);
            end
            G_LD: begin
                x_we  = 1'b1;
                x_val = kk;
            end
            G_ADD: begin
                x_we  = 1'b1;
                x_val = r_vx + kk;
            end
            G_ALU: begin
                unique case (nib)
                    ALU_MOV: begin x_we = 1'b1; x_val = r_vy; end
                    ALU_OR:  begin x_we = 1'b1; x_val = r_vx | r_vy; end
                    ALU_AND: begin x_we = 1'b1; x_val = r_vx & r_vy; end
                    ALU_XOR: begin x_we = 1'b1; x_val = r_vx ^ r_vy; end
                    ALU_ADD: begin
                        x_we = 1'b1; x_val = sum[7:0];
                        f_set = 1'b1; f_val = {7'd0, sum[8]};
                    end
                    ALU_SUB: begin
                        x_we = 1'b1; x_val = r_vx - r_vy;
                        f_set = 1'b1; f_val = {7'd0, (r_vx > r_vy)};
                    end
                    ALU_SHR: begin
                        x_we = 1'b1; x_val = r_vx >> 1;
                        f_set = 1'b1; f_val = {7'd0, r_vx[0]};
                    end
                    ALU_SUBN: begin
                        x_we = 1'b1; x_val = r_vy - r_vx;
                        f_set = 1'b1; f_val = {7'd0, (r_vy > r_vx)};
                    end
                    ALU_SHL: begin
                        x_we = 1'b1; x_val = {r_vx[6:0], 1'b0};
                        f_set = 1'b1; f_val = {7'd0, r_vx[7]};
                    end
                    default: n_bad = 1'b1;
                endcase
            end
            G_SNER: begin
                if (nib != 4'd0) n_bad = 1'b1;
                else             skip = (r_vx != r_vy);
            end
            G_LDI: n_i = nnn;
            G_JPV: n_pc = nnn + {4'd0, r_vy};
            G_RND: begin
                x_we  = 1'b1;
                x_val = r_rnd & kk;
            end
            G_DRW: draw = 1'b1;
            G_KEY: begin
                if (kk == KK_SKP)       skip = key_down;
                else if (kk == KK_SKNP) skip = !key_down;
                else                    n_bad = 1'b1;
            end
            G_MISC: begin
                unique case (kk)
                    KK_LD_VX_DT: begin x_we = 1'b1; x_val = r_dt; end
                    KK_LD_DT:    n_dt = r_vx;
                    KK_LD_ST:    n_st = r_vx;
                    KK_ADD_I:    n_i = r_i + {4'd0, r_vx};
                    KK_LD_F:     n_i = {6'd0, r_vx[3:0], 2'b00} + {8'd0, r_vx[3:0]};
                    default:     n_bad = 1'b1;
                endcase
            end
            default: n_bad = 1'b1;
        endcase
        if (skip) begin
            n_pc = pc_adv + 12'd2;
        end
    end

    // sprite row: byte placed at the column, MSB leftmost, clipped at the right
    logic [63:0] spr_bits;
    assign spr_bits = {m_q, 56'd0} >> r_vx[5:0];

    // memory port steering
    always_comb begin
        v_we    = 1'b0;
        v_waddr = xi;
        v_wdata = x_val;
        if (r_state == S_EXEC && x_we) begin
            v_we = 1'b1;
        end else if (r_state == S_WF) begin
            v_we    = 1'b1;
            v_waddr = 4'hF;
            v_wdata = r_flag;
        end
        if (r_state == S_IDLE) begin
            v_raddr = (t_operation'(i_operation) == OP_REG_READ) ? i_mem_address[3:0]
                                                                 : i_instruction[11:8];
        end else begin
            v_raddr = (grp == G_JPV) ? 4'd0 : r_ins[7:4];
        end

        s_we    = (r_state == S_EXEC) && stk_we;
        s_waddr = sp_inc;
        s_wdata = pc_adv;

        f_we    = (r_state == S_DWR);
        f_waddr = r_drow[RW-1:0];
        f_wdata = frow_q ^ spr_bits;
        f_raddr = (r_state == S_IDLE) ? i_mem_address[RW-1:0] : r_drow[RW-1:0];

        m_we    = (r_state == S_RX) && (r_oper == OP_MEM_WRITE)
                  && ({1'b0, r_maddr} < 13'(MEMORY_BYTES));
        m_waddr = r_maddr[AW-1:0];
        m_raddr = r_daddr[AW-1:0];
    end

    c8ie_ram #(.WIDTH(8), .DEPTH(NUM_VREGS)) u_vregs (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(v_rdata)
    );
    c8ie_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(r_sp), .o_rdata(s_rdata)
    );
    c8ie_ram #(.WIDTH(64), .DEPTH(DISPLAY_ROWS)) u_frame (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rdata)
    );
    c8ie_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(r_mdata),
        .i_raddr(m_raddr), .o_rdata(m_rdata)
    );

    always_ff @(posedge i_clk) begin
        // qualifiers travel alongside each registered read
        r_v_rok    <= r_vok[v_raddr];
        r_s_rok    <= r_stk_ok[r_sp];
        r_f_rok    <= (32'(f_raddr) < DISPLAY_ROWS) && r_row_ok[f_raddr];
        r_font_sel <= (r_daddr < 13'(FONT_BYTES)) && !r_font_wr[r_daddr[6:0]];
        r_font_idx <= r_daddr[6:0];

        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= PC_RESET;
            r_i         <= 12'd0;
            r_vf        <= 8'd0;
            r_dt        <= 8'd0;
            r_st        <= 8'd0;
            r_sp        <= '0;
            r_vok       <= '0;
            r_stk_ok    <= '0;
            r_row_ok    <= '0;
            r_font_wr   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once taken, unless a new one is loaded this cycle
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            if (v_we) begin
                r_vok[v_waddr] <= 1'b1;
                if (v_waddr == 4'hF) begin
                    r_vf <= v_wdata;
                end
            end
            if (s_we) begin
                r_stk_ok[s_waddr] <= 1'b1;
            end
            if (f_we) begin
                r_row_ok[f_waddr] <= 1'b1;
            end
            if (m_we && ({1'b0, r_maddr} < 13'(FONT_BYTES))) begin
                r_font_wr[r_maddr[6:0]] <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_oper  <= t_operation'(i_operation);
                        r_ins   <= i_instruction;
                        r_maddr <= i_mem_address;
                        r_mdata <= i_mem_data;
                        r_rnd   <= i_random_byte;
                        r_keys  <= i_keys_pressed;
                        r_state <= S_RX;
                    end
                end
                S_RX: begin
                    r_vx  <= vreg_q;
                    r_bad <= 1'b0;
                    unique case (r_oper)
                        OP_EXEC: begin
                            r_rd    <= 64'd0;
                            r_state <= S_RY;
                        end
                        OP_MEM_WRITE: begin
                            r_rd    <= 64'd0;
                            r_state <= S_DONE;
                        end
                        OP_ROW_READ: begin
                            r_rd    <= (r_maddr < 12'(DISPLAY_ROWS)) ? frow_q : 64'd0;
                            r_state <= S_DONE;
                        end
                        OP_REG_READ: begin
                            r_rd    <= (r_maddr < 12'(NUM_VREGS)) ? {56'd0, vreg_q} : 64'd0;
                            r_state <= S_DONE;
                        end
                        default: begin
                            r_rd    <= 64'd0;
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_RY: begin
                    r_vy    <= vreg_q;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_pc  <= n_pc;
                    r_i   <= n_i;
                    r_sp  <= n_sp;
                    r_dt  <= n_dt;
                    r_st  <= n_st;
                    r_bad <= n_bad;
                    if (clr) begin
                        r_row_ok <= '0;
                    end
                    r_flag  <= f_val;
                    r_daddr <= {1'b0, r_i};
                    r_drow  <= r_vy;
                    r_di    <= 4'd0;
                    r_hit   <= 1'b0;
                    if (draw)       r_state <= S_DMOD;
                    else if (f_set) r_state <= S_WF;
                    else            r_state <= S_DONE;
                end
                S_DMOD: begin
                    // bring I and the start row into range one subtraction at a time
                    if (r_daddr >= 13'(MEMORY_BYTES)) begin
                        r_daddr <= r_daddr - 13'(MEMORY_BYTES);
                    end
                    if (r_drow >= 8'(DISPLAY_ROWS)) begin
                        r_drow <= r_drow - 8'(DISPLAY_ROWS);
                    end
                    if (r_daddr < 13'(MEMORY_BYTES) && r_drow < 8'(DISPLAY_ROWS)) begin
                        r_state <= S_DRD;
                    end
                end
                S_DRD: begin
                    if (r_di == nib || r_drow >= 8'(DISPLAY_ROWS)) begin
                        r_flag  <= {7'd0, r_hit};
                        r_state <= S_WF;
                    end else begin
                        r_state <= S_DWR;
                    end
                end
                S_DWR: begin
                    if ((spr_bits & frow_q) != 64'd0) r_hit <= 1'b1;
                    r_di    <= r_di + 4'd1;
                    r_drow  <= r_drow + 8'd1;
                    r_daddr <= (r_daddr + 13'd1 == 13'(MEMORY_BYTES)) ? 13'd0
                                                                      : r_daddr + 13'd1;
                    r_state <= S_DRD;
                end
                S_WF: r_state <= S_DONE;
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_o_pc      <= r_pc;
                        r_o_i       <= r_i;
                        r_o_vf      <= r_vf;
                        r_o_rd      <= r_rd;
                        r_o_bad     <= r_bad;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_program_counter = r_o_pc;
    assign o_index_register  = r_o_i;
    assign o_flag_register   = r_o_vf;
    assign o_read_data       = r_o_rd;
    assign o_not_implemented = r_o_bad;

    `CHK_NEXT(a_accept_reads, i_clk, i_rst_n, in_acc, r_state == S_RX, "accept did not start read")
    `CHK_IMPL(a_sp_range, i_clk, i_rst_n, 1'b1, r_sp <= SW'(STACK_DEPTH - 1), "stack index out of range")
    `CHK_IMPL(a_bad_no_data, i_clk, i_rst_n, o_out_valid && o_not_implemented, o_read_data == 64'd0, "unimplemented op carries data")
    `CHK_IMPL(a_draw_bounds, i_clk, i_rst_n, r_state == S_DWR, (r_drow < 8'(DISPLAY_ROWS)) && (r_di != nib), "draw row past limit")

endmodule
`default_nettype wire
